>>> sv/rsd_pkg.sv
// Shared types and fixed widths for the descending record sorter.
// No dependencies; imported by every module of the block except rsd_ram.
package rsd_pkg;

   localparam int SCORE_W     = 32;
   localparam int TAG_W       = 16;
   localparam int RANK_W      = 6;
   localparam int REC_W       = SCORE_W + TAG_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One record as it leaves the front queue
   typedef struct packed {
      logic               last;
      logic [TAG_W-1:0]   tag;
      logic [SCORE_W-1:0] score;
   } record_type;

   // Head of the front queue as seen by the back end
   typedef struct packed {
      logic       valid;
      record_type rec;
   } queue_link_type;

   // Stored table entry (score in the low bits)
   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [SCORE_W-1:0] score;
   } entry_type;

   // One result request
   typedef struct packed {
      logic               overflow;
      logic               final_flag;
      logic [RANK_W-1:0]  rank;
      logic [TAG_W-1:0]   tag;
      logic [SCORE_W-1:0] score;
   } result_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CARRY_RD,
      ST_CARRY_LD,
      ST_STEP_RD,
      ST_STEP_CMP,
      ST_PASS_END,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_HOLD
   } back_state_type;

endpackage

>>> sv/rsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/rsd_front.sv
// Front end: accepts record requests and holds them in a short queue.
// Depends on rsd_pkg.
module rsd_front
   import rsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REC_W-1:0]      req_tdata,
   input  logic                  req_tlast,
   output queue_link_type        q_head,
   input  logic                  q_pop
);

   record_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     fill_ff, fill_in;
   logic                push;
   logic                pop;
   record_type          rec_in;

   assign req_tready = (fill_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && (fill_ff != '0);

   // classify the incoming request into score, tag and end-of-set mark
   always_comb begin
      rec_in.score = req_tdata[SCORE_W-1:0];
      rec_in.tag   = req_tdata[REC_W-1:SCORE_W];
      rec_in.last  = req_tlast;
   end

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage, payload only
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= rec_in;
      end
   end

   assign q_head.valid = (fill_ff != '0);
   assign q_head.rec   = slot_ff[rd_ptr_ff];

endmodule

>>> sv/rsd_back.sv
// Back end: loads records into the table RAM, bubble-sorts it and emits results.
// Depends on rsd_pkg and rsd_ram.
module rsd_back
   import rsd_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_link_type q_head,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output result_type     rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   back_state_type   state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [AW-1:0]    pass_ff, pass_in;
   logic [AW-1:0]    j_ff, j_in;
   logic [AW-1:0]    k_ff, k_in;
   entry_type        carry_ff, carry_in;
   result_type       out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   entry_type        ram_wdata;
   logic             ram_re;
   logic [AW-1:0]    ram_raddr;
   logic [REC_W-1:0] ram_rdata;
   entry_type        rd_entry;
   logic [CW-1:0]    cnt_m1;
   logic             room;
   logic [CW-1:0]    n_next;

   assign rd_entry = entry_type'(ram_rdata);
   assign cnt_m1   = count_ff - 1'b1;
   assign room     = (count_ff < CW'(DEPTH));
   assign n_next   = room ? count_ff + 1'b1 : count_ff;

   rsd_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (REC_W'(ram_wdata)),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // state register and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload and loop indices
   always_ff @(posedge clock) begin
      pass_ff  <= pass_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      carry_ff <= carry_in;
      out_ff   <= out_in;
   end

   // sequencer: load, sort passes (carry bubbles towards index pass), emit
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      pass_in      = pass_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      carry_in     = carry_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = carry_ff;
      ram_re       = 1'b0;
      ram_raddr    = j_ff - 1'b1;

      unique case (state_ff)
         ST_LOAD: begin
            q_pop     = q_head.valid;
            ram_wdata.score = q_head.rec.score;
            ram_wdata.tag   = q_head.rec.tag;
            if (q_head.valid) begin
               if (room) begin
                  ram_we   = 1'b1;
                  count_in = n_next;
               end else begin
                  dropped_in = 1'b1;
               end
               if (q_head.rec.last) begin
                  pass_in = '0;
                  k_in    = '0;
                  // a single record needs no sorting
                  state_in = (n_next > CW'(1)) ? ST_CARRY_RD : ST_EMIT_RD;
               end
            end
         end

         ST_CARRY_RD: begin
            ram_re    = 1'b1;
            ram_raddr = cnt_m1[AW-1:0];
            j_in      = cnt_m1[AW-1:0];
            state_in  = ST_CARRY_LD;
         end

         ST_CARRY_LD: begin
            carry_in = rd_entry;
            state_in = ST_STEP_RD;
         end

         ST_STEP_RD: begin
            ram_re    = 1'b1;
            ram_raddr = j_ff - 1'b1;
            state_in  = ST_STEP_CMP;
         end

         ST_STEP_CMP: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            if ($signed(rd_entry.score) < $signed(carry_ff.score)) begin
               // lower entry moves down, carry keeps rising
               ram_wdata = rd_entry;
            end else begin
               // ties and larger: carry settles, lower entry becomes carry
               ram_wdata = carry_ff;
               carry_in  = rd_entry;
            end
            if ((j_ff - 1'b1) == pass_ff) begin
               state_in = ST_PASS_END;
            end else begin
               j_in     = j_ff - 1'b1;
               state_in = ST_STEP_RD;
            end
         end

         ST_PASS_END: begin
            ram_we    = 1'b1;
            ram_waddr = pass_ff;
            ram_wdata = carry_ff;
            if (CW'(pass_ff) + 1'b1 == cnt_m1) begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               pass_in  = pass_ff + 1'b1;
               state_in = ST_CARRY_RD;
            end
         end

         ST_EMIT_RD: begin
            ram_re    = 1'b1;
            ram_raddr = k_ff;
            state_in  = ST_EMIT_LD;
         end

         ST_EMIT_LD: begin
            out_in.score      = rd_entry.score;
            out_in.tag        = rd_entry.tag;
            out_in.rank       = RANK_W'(k_ff);
            out_in.final_flag = (CW'(k_ff) == cnt_m1);
            out_in.overflow   = dropped_ff;
            out_valid_in      = 1'b1;
            state_in          = ST_EMIT_HOLD;
         end

         ST_EMIT_HOLD: begin
            if (rsp_ready) begin
               out_valid_in = 1'b0;
               if (out_ff.final_flag) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // a result is only shown while the sequencer waits on the receiver
   a_valid_in_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> state_ff == ST_EMIT_HOLD)
      else $error("result valid outside emit hold");

   // the table never holds more than its capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("record count beyond capacity");

   // a record can only be dropped once the table is full
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> count_ff == CW'(DEPTH))
      else $error("drop flag set with room in table");

   // a compare step always lies above the settled part of the table
   a_step_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP_RD || state_ff == ST_STEP_CMP) |-> j_ff > pass_ff)
      else $error("sort step index below pass index");

   // the queue is only drained while loading
   a_pop_load: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.valid) |=> (state_ff == ST_LOAD || $past(q_head.rec.last)))
      else $error("queue popped outside load phase");

endmodule

>>> sv/record_sort_descending_core.sv
// Descending record sorter, top level.
// Depends on rsd_pkg, rsd_front, rsd_back (and rsd_ram below it).
//
// Usage:
//   req_*  carries score records. A request is taken when req_tvalid and
//          req_tready are both high; req_tlast marks the final record of a set.
//          Records load at one per cycle outside sort and emit, into a table of DEPTH
//          entries (2 to 64); records beyond DEPTH are dropped and flagged.
//   rsp_*  after the last record, the table is bubble-sorted (descending,
//          ties keep load order) and one response per held record is sent,
//          rank 0 first, rsp_tlast on the final one, rsp_tuser = overflow.
// Timing:
//   Loading runs at one record per cycle through a four-entry queue while
//   the back end is in its load state. The sort takes n-1 passes over the
//   table RAM (one write port, one read port); each response is then read
//   from the table, registered and held until the receiver takes it.
//   The front queue keeps accepting records while the back end sorts or
//   emits, until it is full.
// Reset: synchronous; clears the queue, the record count and the drop flag.
//   The table contents are not cleared; only written entries are ever read.
// A stalled response holds in the output register until rsp_tready is high.
module record_sort_descending_core
   import rsd_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // score[31:0], tag[47:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // sorted_score[31:0], sorted_tag[47:32],
                                    // rank[53:48], zero[55:54]
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser    // overflow[0]
);

   queue_link_type q_head;
   logic           q_pop;
   logic           rsp_valid;
   result_type     rsp_data;

   rsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   rsd_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   // response packing
   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {2'b00, rsp_data.rank, rsp_data.tag, rsp_data.score};
   assign rsp_tlast  = rsp_data.final_flag;
   assign rsp_tuser  = rsp_data.overflow;

endmodule
